// ----- rtl/core/msmd_pkg.sv -----
// ============================================================================
// msmd_pkg - MIDI stream message decoder package
// Shared constants, command and event codes, and controller/datapath links.
// ============================================================================
`default_nettype none

package msmd_pkg;

    localparam int SYSEX_CAPACITY = 32;
    localparam int STORE_AW       = $clog2(SYSEX_CAPACITY);
    localparam int FILL_W         = $clog2(SYSEX_CAPACITY + 1);

    localparam logic [7:0] EOX_BYTE = 8'hF7;

    localparam logic [3:0] CMD_NOTE_OFF   = 4'd0;
    localparam logic [3:0] CMD_NOTE_ON    = 4'd1;
    localparam logic [3:0] CMD_POLY_PRESS = 4'd2;
    localparam logic [3:0] CMD_CONTROL    = 4'd3;
    localparam logic [3:0] CMD_PROGRAM    = 4'd4;
    localparam logic [3:0] CMD_MONO_PRESS = 4'd5;
    localparam logic [3:0] CMD_BEND       = 4'd6;
    localparam logic [3:0] CMD_SYSTEM     = 4'd7;
    localparam logic [3:0] CMD_UNKNOWN    = 4'd8;

    localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_CONTROL  = 3'd2;
    localparam logic [2:0] KIND_PROGRAM  = 3'd3;
    localparam logic [2:0] KIND_BEND     = 3'd4;
    localparam logic [2:0] KIND_SYSEX    = 3'd5;

    typedef struct packed {
        logic latch_byte;
        logic apply_status;
        logic store_data;
        logic load_event;
        logic load_empty;
        logic load_flush;
        logic mem_read;
        logic k_clear;
        logic k_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_status;
        logic cmd_is_sys;
        logic fill_zero;
        logic rem_active;
        logic rem_last;
        logic event_none;
        logic out_last;
    } dp_status_t;

    // Expected data byte count for a status command nibble.
    function automatic logic [FILL_W-1:0] data_count(input logic [2:0] cmd);
        logic [FILL_W-1:0] n;
        begin
            unique case ({1'b0, cmd}) inside
                CMD_PROGRAM, CMD_MONO_PRESS: n = FILL_W'(1);
                CMD_SYSTEM:                  n = FILL_W'(SYSEX_CAPACITY);
                default:                     n = FILL_W'(2);
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/msmd_ctrl.sv -----
// ============================================================================
// msmd_ctrl - MIDI decoder controller
// Sequences byte decode, event dispatch and sysex flush over the datapath.
// ============================================================================
`default_nettype none

module msmd_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    input  msmd_pkg::dp_status_t  st,
    output msmd_pkg::ctrl_cmd_t   ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_FLUSH_RD = 3'd3;
    localparam logic [2:0] S_FLUSH_LD = 3'd4;
    localparam logic [2:0] S_SHOW     = 3'd5;
    localparam logic [2:0] S_APPLY    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       flush_reg;
    logic       flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.latch_byte = 1'b1;
                    state_next     = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.is_status)
                begin
                    if (st.cmd_is_sys)
                    begin
                        flush_next  = 1'b1;
                        ctl.k_clear = 1'b1;
                        if (st.fill_zero)
                        begin
                            ctl.load_empty = 1'b1;
                            state_next     = S_SHOW;
                        end
                        else
                        begin
                            state_next = S_FLUSH_RD;
                        end
                    end
                    else
                    begin
                        ctl.apply_status = 1'b1;
                        state_next       = S_IDLE;
                    end
                end
                else if (st.rem_active)
                begin
                    ctl.store_data = 1'b1;
                    state_next     = st.rem_last ? S_DISPATCH : S_IDLE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DISPATCH:
            begin
                if (st.event_none)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.load_event = 1'b1;
                    state_next     = S_SHOW;
                end
            end
            S_FLUSH_RD:
            begin
                ctl.mem_read = 1'b1;
                state_next   = S_FLUSH_LD;
            end
            S_FLUSH_LD:
            begin
                ctl.load_flush = 1'b1;
                state_next     = S_SHOW;
            end
            S_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (!flush_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (st.out_last)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        ctl.k_inc  = 1'b1;
                        state_next = S_FLUSH_RD;
                    end
                end
            end
            S_APPLY:
            begin
                ctl.apply_status = 1'b1;
                flush_next       = 1'b0;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
                flush_next = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/msmd_dp.sv -----
// ============================================================================
// msmd_dp - MIDI decoder datapath
// Command state, data store, event formatting and the result register.
// ============================================================================
`default_nettype none

module msmd_dp
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  [7:0]                  rx_byte,
    input  msmd_pkg::ctrl_cmd_t         ctl,
    output msmd_pkg::dp_status_t        st,
    output logic [2:0]                  event_kind,
    output logic [3:0]                  channel,
    output logic [6:0]                  data_first,
    output logic [6:0]                  data_second,
    output logic signed [13:0]          bend_value,
    output logic [msmd_pkg::FILL_W-1:0] sysex_length,
    output logic                        last_of_run
);

    localparam int FW = msmd_pkg::FILL_W;
    localparam int AW = msmd_pkg::STORE_AW;

    logic [6:0]    store_mem [msmd_pkg::SYSEX_CAPACITY];
    logic [6:0]    rd_data_reg;

    logic [7:0]    byte_reg;
    logic [3:0]    cmd_reg;
    logic [3:0]    cmd_next;
    logic [3:0]    chan_reg;
    logic [3:0]    chan_next;
    logic [FW-1:0] rem_reg;
    logic [FW-1:0] rem_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] k_reg;
    logic [FW-1:0] k_next;
    logic [6:0]    d0_reg;
    logic [6:0]    d1_reg;

    logic          store_we;
    logic          ev_none;
    logic [2:0]    ev_kind;
    logic [6:0]    ev_first;
    logic [6:0]    ev_second;
    logic [13:0]   ev_bend;

    assign store_we = ctl.store_data && (fill_reg < FW'(msmd_pkg::SYSEX_CAPACITY));

    always_comb
    begin
        cmd_next  = cmd_reg;
        chan_next = chan_reg;
        rem_next  = rem_reg;
        fill_next = fill_reg;
        if (ctl.apply_status)
        begin
            if (cmd_reg == msmd_pkg::CMD_SYSTEM && byte_reg == msmd_pkg::EOX_BYTE)
            begin
                cmd_next  = msmd_pkg::CMD_UNKNOWN;
                rem_next  = '0;
                fill_next = '0;
            end
            else
            begin
                cmd_next  = {1'b0, byte_reg[6:4]};
                chan_next = byte_reg[3:0];
                rem_next  = msmd_pkg::data_count(byte_reg[6:4]);
                fill_next = '0;
            end
        end
        else if (ctl.store_data)
        begin
            rem_next = rem_reg - FW'(1);
            if (store_we)
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    always_comb
    begin
        k_next = k_reg;
        if (ctl.k_clear)
        begin
            k_next = '0;
        end
        else if (ctl.k_inc)
        begin
            k_next = k_reg + FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg  <= msmd_pkg::CMD_UNKNOWN;
            chan_reg <= 4'hF;
            rem_reg  <= '0;
            fill_reg <= '0;
            k_reg    <= '0;
        end
        else
        begin
            cmd_reg  <= cmd_next;
            chan_reg <= chan_next;
            rem_reg  <= rem_next;
            fill_reg <= fill_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[fill_reg[AW-1:0]] <= byte_reg[6:0];
        end
        if (ctl.mem_read)
        begin
            rd_data_reg <= store_mem[k_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch_byte)
        begin
            byte_reg <= rx_byte;
        end
        if (store_we && fill_reg == FW'(0))
        begin
            d0_reg <= byte_reg[6:0];
        end
        if (store_we && fill_reg == FW'(1))
        begin
            d1_reg <= byte_reg[6:0];
        end
    end

    // Channel event formatting from the first two data bytes.
    always_comb
    begin
        ev_none   = 1'b0;
        ev_kind   = msmd_pkg::KIND_NOTE_OFF;
        ev_first  = d0_reg;
        ev_second = '0;
        ev_bend   = '0;
        unique case (cmd_reg)
            msmd_pkg::CMD_NOTE_OFF:
            begin
                ev_kind = msmd_pkg::KIND_NOTE_OFF;
            end
            msmd_pkg::CMD_NOTE_ON:
            begin
                if (d1_reg != 7'd0)
                begin
                    ev_kind   = msmd_pkg::KIND_NOTE_ON;
                    ev_second = d1_reg;
                end
            end
            msmd_pkg::CMD_CONTROL:
            begin
                ev_kind   = msmd_pkg::KIND_CONTROL;
                ev_second = d1_reg;
            end
            msmd_pkg::CMD_PROGRAM:
            begin
                ev_kind = msmd_pkg::KIND_PROGRAM;
            end
            msmd_pkg::CMD_BEND:
            begin
                ev_kind  = msmd_pkg::KIND_BEND;
                ev_first = '0;
                ev_bend  = {~d1_reg[6], d1_reg[5:0], d0_reg};
            end
            default:
            begin
                ev_none = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_event)
        begin
            event_kind   <= ev_kind;
            channel      <= chan_reg;
            data_first   <= ev_first;
            data_second  <= ev_second;
            bend_value   <= $signed(ev_bend);
            sysex_length <= '0;
            last_of_run  <= 1'b1;
        end
        else if (ctl.load_empty)
        begin
            event_kind   <= msmd_pkg::KIND_SYSEX;
            channel      <= chan_reg;
            data_first   <= '0;
            data_second  <= '0;
            bend_value   <= '0;
            sysex_length <= '0;
            last_of_run  <= 1'b1;
        end
        else if (ctl.load_flush)
        begin
            event_kind   <= msmd_pkg::KIND_SYSEX;
            channel      <= chan_reg;
            data_first   <= rd_data_reg;
            data_second  <= '0;
            bend_value   <= '0;
            sysex_length <= fill_reg;
            last_of_run  <= (k_reg + FW'(1)) == fill_reg;
        end
    end

    assign st.is_status  = byte_reg[7];
    assign st.cmd_is_sys = cmd_reg == msmd_pkg::CMD_SYSTEM;
    assign st.fill_zero  = fill_reg == '0;
    assign st.rem_active = rem_reg != '0;
    assign st.rem_last   = rem_reg == FW'(1);
    assign st.event_none = ev_none;
    assign st.out_last   = last_of_run;

endmodule

`default_nettype wire

// ----- rtl/core/midi_stream_message_decoder.sv -----
// ============================================================================
// midi_stream_message_decoder - MIDI byte stream to event decoder
// Parses status and data bytes into channel events and sysex runs.
// ============================================================================
//
//   channel | signals                                   | width
//   --------+-------------------------------------------+-------------------
//   in      | in_valid, in_ready, rx_byte               | 8
//   out     | out_valid, out_ready, event_kind, channel,| 3, 4, 7, 7, 14s,
//           | data_first, data_second, bend_value,      | 6, 1
//           | sysex_length, last_of_run                 |
//
// One item at a time: a byte is latched and then decoded; one that completes
// a channel event goes on to dispatch and waits in show until it is taken.
// A sysex flush steps through store read, load and show for each stored
// byte, since the store read is registered.
// Reset is asynchronous; it clears counts and the sequencer, sets the command to unknown and the channel to 15.
// A stalled result holds the sequencer in place; in_ready stays low until
// every result of the current item has been taken.
// ============================================================================
`default_nettype none

module midi_stream_message_decoder
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire  [7:0]                  rx_byte,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [2:0]                  event_kind,
    output logic [3:0]                  channel,
    output logic [6:0]                  data_first,
    output logic [6:0]                  data_second,
    output logic signed [13:0]          bend_value,
    output logic [msmd_pkg::FILL_W-1:0] sysex_length,
    output logic                        last_of_run
);

    msmd_pkg::ctrl_cmd_t  ctl;
    msmd_pkg::dp_status_t st;

    msmd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .ctl       (ctl)
    );

    msmd_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .ctl          (ctl),
        .st           (st),
        .event_kind   (event_kind),
        .channel      (channel),
        .data_first   (data_first),
        .data_second  (data_second),
        .bend_value   (bend_value),
        .sysex_length (sysex_length),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire
